### rtl/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types, register codes and substitution tables of the pixel combiner.
// ----------------------------------------------------------------------------
`default_nettype none

package bdpc_pkg;

	localparam int DATA_W  = 32;
	localparam int PIXEL_W = 16;
	localparam int CHAN_W  = 6;
	localparam int PROD_W  = 12;
	localparam int NUM_CH  = 3;
	localparam int PADDR_W = 5;

	localparam int CH_BLU = 0;
	localparam int CH_GRN = 1;
	localparam int CH_RED = 2;

	localparam int FLAG_SUB   = 0;
	localparam int FLAG_KEY   = 1;
	localparam int FLAG_ARGB  = 2;
	localparam int FLAG_ALPHA = 3;
	localparam int FLAG_DESCR = 4;

	typedef enum logic [1:0] {
		OP_IDLE  = 2'd0,
		OP_COPY  = 2'd1,
		OP_BLEND = 2'd2,
		OP_FILL  = 2'd3
	} op_mode_t;

	typedef enum logic [2:0] {
		REG_OP_MODE  = 3'd0,
		REG_FLAGS    = 3'd1,
		REG_KEY      = 3'd2,
		REG_FILL     = 3'd3,
		REG_FACTOR_A = 3'd4,
		REG_FACTOR_B = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		RES_NONE  = 2'd0,
		RES_PIXEL = 2'd1,
		RES_WORD  = 2'd2,
		RES_BLEND = 2'd3
	} res_kind_t;

	typedef struct packed {
		op_mode_t            op_mode;
		logic [4:0]          flags;
		logic [PIXEL_W-1:0]  colour_key;
		logic [PIXEL_W-1:0]  fill_pattern;
		logic [CHAN_W-1:0]   factor_a;
		logic [CHAN_W-1:0]   factor_b;
	} cfg_t;

	typedef struct packed {
		res_kind_t                       kind;
		logic [DATA_W-1:0]               val;
		logic [NUM_CH-1:0][CHAN_W-1:0]   ch_a;
		logic [NUM_CH-1:0][CHAN_W-1:0]   ch_b;
	} dec_t;

	typedef struct packed {
		res_kind_t                       kind;
		logic [DATA_W-1:0]               val;
		logic [NUM_CH-1:0][PROD_W-1:0]   prod_a;
		logic [NUM_CH-1:0][PROD_W-1:0]   prod_b;
	} prod_t;

	typedef logic [4:0] bitpos_t;
	typedef logic [3:0] nib_t;

	localparam bitpos_t GRP_BITS [8][4] = '{
		'{5'd0, 5'd14, 5'd16, 5'd21}, '{5'd1, 5'd9,  5'd19, 5'd27},
		'{5'd2, 5'd17, 5'd20, 5'd28}, '{5'd3, 5'd10, 5'd18, 5'd25},
		'{5'd4, 5'd5,  5'd26, 5'd31}, '{5'd6, 5'd15, 5'd22, 5'd30},
		'{5'd7, 5'd12, 5'd13, 5'd24}, '{5'd8, 5'd11, 5'd23, 5'd29}
	};

	localparam nib_t GRP_SUB [8][16] = '{
		'{4'h4,4'hE,4'hC,4'h6,4'h1,4'hB,4'h9,4'h3,4'h8,4'h2,4'h0,4'hA,4'hD,4'h7,4'h5,4'hF},
		'{4'hA,4'h6,4'h2,4'h9,4'h0,4'h5,4'h1,4'hF,4'hC,4'h8,4'hE,4'h4,4'h7,4'hB,4'h3,4'hD},
		'{4'h8,4'hC,4'h9,4'hD,4'h5,4'h7,4'h1,4'hB,4'h6,4'h3,4'hF,4'h0,4'hA,4'hE,4'h4,4'h2},
		'{4'h9,4'h7,4'h1,4'h0,4'h8,4'hD,4'hF,4'h5,4'hA,4'h4,4'hC,4'hE,4'h6,4'h2,4'h3,4'hB},
		'{4'h6,4'h9,4'hA,4'h5,4'h3,4'h8,4'h7,4'h1,4'hC,4'h4,4'h2,4'hB,4'hF,4'h0,4'hD,4'hE},
		'{4'hF,4'h5,4'h7,4'h1,4'hE,4'h6,4'hC,4'h0,4'hD,4'h8,4'h9,4'h4,4'hB,4'h3,4'hA,4'h2},
		'{4'h6,4'hF,4'h4,4'h9,4'h8,4'h0,4'hE,4'hA,4'h2,4'hC,4'h3,4'h1,4'hB,4'h7,4'hD,4'h5},
		'{4'h5,4'hF,4'h1,4'h0,4'hE,4'hC,4'h2,4'h9,4'h6,4'h3,4'h8,4'hB,4'h7,4'hA,4'hD,4'h4}
	};

	function automatic logic [DATA_W-1:0] unscramble(input logic [DATA_W-1:0] w);
		logic [DATA_W-1:0] res;
		nib_t              code;
		nib_t              sub;
		res = '0;
		for (int gi = 0; gi < 8; gi++) begin
			for (int k = 0; k < 4; k++) begin
				code[k] = w[GRP_BITS[gi][k]];
			end
			sub = GRP_SUB[gi][code];
			for (int k = 0; k < 4; k++) begin
				res[GRP_BITS[gi][k]] = sub[k];
			end
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### rtl/bdpc_cfg.sv
// ----------------------------------------------------------------------------
// bdpc_cfg
// Configuration register file behind an APB-style slave port.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_cfg
	import bdpc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic      [DATA_W-1:0]  prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_OP_MODE:  cfg_q.op_mode      <= op_mode_t'(pwdata[1:0]);
				REG_FLAGS:    cfg_q.flags        <= pwdata[4:0];
				REG_KEY:      cfg_q.colour_key   <= pwdata[PIXEL_W-1:0];
				REG_FILL:     cfg_q.fill_pattern <= pwdata[PIXEL_W-1:0];
				REG_FACTOR_A: cfg_q.factor_a     <= pwdata[CHAN_W-1:0];
				REG_FACTOR_B: cfg_q.factor_b     <= pwdata[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_OP_MODE:  prdata = {30'b0, cfg_q.op_mode};
			REG_FLAGS:    prdata = {27'b0, cfg_q.flags};
			REG_KEY:      prdata = {16'b0, cfg_q.colour_key};
			REG_FILL:     prdata = {16'b0, cfg_q.fill_pattern};
			REG_FACTOR_A: prdata = {26'b0, cfg_q.factor_a};
			REG_FACTOR_B: prdata = {26'b0, cfg_q.factor_b};
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### rtl/bdpc_decode.sv
// ----------------------------------------------------------------------------
// bdpc_decode
// First stage: mode decode, key and alpha filter, descramble, channel split.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_decode
	import bdpc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              up_valid,
	output logic                   up_stall,
	input  wire logic [DATA_W-1:0] src_a_word,
	input  wire logic [PIXEL_W-1:0] src_b_pixel,
	output logic                   dn_valid,
	input  wire logic              dn_stall,
	output dec_t                   dn_data
);

	logic               v_s1;
	dec_t               dec_s1;
	dec_t               dec_d;
	logic               adv;
	logic               alpha_on;
	logic [PIXEL_W-1:0] pa;
	logic [PIXEL_W-1:0] pb;

	function automatic logic dropped(input cfg_t c, input logic [PIXEL_W-1:0] px);
		return (c.flags[FLAG_KEY] && (px == c.colour_key)) ||
			(c.flags[FLAG_ARGB] && c.flags[FLAG_ALPHA] && px[PIXEL_W-1]);
	endfunction

	assign adv      = !v_s1 || !dn_stall;
	assign up_stall = !adv;
	assign dn_valid = v_s1;
	assign dn_data  = dec_s1;
	assign alpha_on = cfg.flags[FLAG_ARGB] && cfg.flags[FLAG_ALPHA];

	// alpha-marked pixels contribute zero channels
	assign pa = (alpha_on && src_a_word[PIXEL_W-1]) ? '0 : src_a_word[PIXEL_W-1:0];
	assign pb = (alpha_on && src_b_pixel[PIXEL_W-1]) ? '0 : src_b_pixel;

	always_comb begin
		dec_d      = '0;
		dec_d.kind = RES_NONE;
		dec_d.ch_a[CH_BLU] = {1'b0, pa[4:0]};
		dec_d.ch_b[CH_BLU] = {1'b0, pb[4:0]};
		if (cfg.flags[FLAG_ARGB]) begin
			dec_d.ch_a[CH_GRN] = {1'b0, pa[9:5]};
			dec_d.ch_b[CH_GRN] = {1'b0, pb[9:5]};
			dec_d.ch_a[CH_RED] = {1'b0, pa[14:10]};
			dec_d.ch_b[CH_RED] = {1'b0, pb[14:10]};
		end else begin
			dec_d.ch_a[CH_GRN] = pa[10:5];
			dec_d.ch_b[CH_GRN] = pb[10:5];
			dec_d.ch_a[CH_RED] = {1'b0, pa[15:11]};
			dec_d.ch_b[CH_RED] = {1'b0, pb[15:11]};
		end
		case (cfg.op_mode)
			OP_COPY: begin
				if (cfg.flags[FLAG_DESCR]) begin
					dec_d.kind = RES_WORD;
					dec_d.val  = unscramble(src_a_word);
				end else if (!dropped(cfg, src_a_word[PIXEL_W-1:0])) begin
					dec_d.kind = RES_PIXEL;
					dec_d.val  = {16'b0, src_a_word[PIXEL_W-1:0]};
				end
			end
			OP_BLEND: begin
				dec_d.kind = RES_BLEND;
			end
			OP_FILL: begin
				if (!dropped(cfg, cfg.fill_pattern)) begin
					dec_d.kind = RES_PIXEL;
					dec_d.val  = {16'b0, cfg.fill_pattern};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && up_valid) begin
			dec_s1 <= dec_d;
		end
	end

endmodule

`default_nettype wire

### rtl/bdpc_mult.sv
// ----------------------------------------------------------------------------
// bdpc_mult
// Second stage: per-channel factor weighting of source A and source B.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_mult
	import bdpc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic up_valid,
	output logic      up_stall,
	input  wire dec_t up_data,
	output logic      dn_valid,
	input  wire logic dn_stall,
	output prod_t     dn_data
);

	logic  v_s2;
	prod_t prod_s2;
	prod_t prod_d;
	logic  adv;

	assign adv      = !v_s2 || !dn_stall;
	assign up_stall = !adv;
	assign dn_valid = v_s2;
	assign dn_data  = prod_s2;

	always_comb begin
		prod_d.kind = up_data.kind;
		prod_d.val  = up_data.val;
		for (int c = 0; c < NUM_CH; c++) begin
			prod_d.prod_a[c] = PROD_W'(up_data.ch_a[c]) * PROD_W'(cfg.factor_a);
			prod_d.prod_b[c] = PROD_W'(up_data.ch_b[c]) * PROD_W'(cfg.factor_b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && up_valid) begin
			prod_s2 <= prod_d;
		end
	end

endmodule

`default_nettype wire

### rtl/bdpc_combine.sv
// ----------------------------------------------------------------------------
// bdpc_combine
// Third stage: channel add or subtract, shift, wrap mask and result select.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_combine
	import bdpc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               up_valid,
	output logic                    up_stall,
	input  wire prod_t              up_data,
	output logic                    dn_valid,
	input  wire logic               dn_stall,
	output logic [DATA_W-1:0]       out_value,
	output logic                    write_enable,
	output logic                    word_write
);

	logic                          v_s3;
	logic [DATA_W-1:0]             val_s3;
	logic                          we_s3;
	logic                          word_s3;
	logic                          adv;
	logic [NUM_CH-1:0][PROD_W-1:0] sum;
	logic [PIXEL_W-1:0]            pix;
	logic [DATA_W-1:0]             val_d;
	logic                          we_d;
	logic                          word_d;

	assign adv          = !v_s3 || !dn_stall;
	assign up_stall     = !adv;
	assign dn_valid     = v_s3;
	assign out_value    = val_s3;
	assign write_enable = we_s3;
	assign word_write   = word_s3;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			sum[c] = cfg.flags[FLAG_SUB] ? (up_data.prod_a[c] - up_data.prod_b[c])
				: (up_data.prod_a[c] + up_data.prod_b[c]);
		end
		if (cfg.flags[FLAG_ARGB]) begin
			pix = {1'b0, sum[CH_RED][10:6], sum[CH_GRN][10:6], sum[CH_BLU][10:6]};
		end else begin
			pix = {sum[CH_RED][10:6], sum[CH_GRN][11:6], sum[CH_BLU][10:6]};
		end
		case (up_data.kind)
			RES_PIXEL: begin
				val_d  = up_data.val;
				we_d   = 1'b1;
				word_d = 1'b0;
			end
			RES_WORD: begin
				val_d  = up_data.val;
				we_d   = 1'b1;
				word_d = 1'b1;
			end
			RES_BLEND: begin
				val_d  = {16'b0, pix};
				we_d   = 1'b1;
				word_d = 1'b0;
			end
			default: begin
				val_d  = '0;
				we_d   = 1'b0;
				word_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && up_valid) begin
			val_s3  <= val_d;
			we_s3   <= we_d;
			word_s3 <= word_d;
		end
	end

endmodule

`default_nettype wire

### rtl/blend_dma_pixel_combiner.sv
// ----------------------------------------------------------------------------
// blend_dma_pixel_combiner
// Per-pixel datapath of a blending DMA engine: copy, blend and fill.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless in_stall is high and returns one
// result per request through three stages: decode and filter, channel
// multiply, then combine into the output register. Each stage holds its own
// valid bit, so a stall on the output fills empty stages before it reaches
// in_stall. Registers are written through the APB port at byte address 4*i
// and should only be changed while no request is in flight.
`default_nettype none

module blend_dma_pixel_combiner
	import bdpc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic      [DATA_W-1:0]  prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [DATA_W-1:0]  src_a_word,
	input  wire logic [PIXEL_W-1:0] src_b_pixel,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic      [DATA_W-1:0]  out_value,
	output logic                    write_enable,
	output logic                    word_write
);

	cfg_t  cfg;
	logic  dec_valid;
	logic  dec_stall;
	dec_t  dec_data;
	logic  prod_valid;
	logic  prod_stall;
	prod_t prod_data;

	bdpc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bdpc_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.up_valid    (in_valid),
		.up_stall    (in_stall),
		.src_a_word  (src_a_word),
		.src_b_pixel (src_b_pixel),
		.dn_valid    (dec_valid),
		.dn_stall    (dec_stall),
		.dn_data     (dec_data)
	);

	bdpc_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (dec_valid),
		.up_stall (dec_stall),
		.up_data  (dec_data),
		.dn_valid (prod_valid),
		.dn_stall (prod_stall),
		.dn_data  (prod_data)
	);

	bdpc_combine u_combine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.up_valid     (prod_valid),
		.up_stall     (prod_stall),
		.up_data      (prod_data),
		.dn_valid     (out_valid),
		.dn_stall     (out_stall),
		.out_value    (out_value),
		.write_enable (write_enable),
		.word_write   (word_write)
	);

endmodule

`default_nettype wire
